// File: hdl/pzpt_pkg.sv
// Shared types, codes and defaults for the polygon zone point test.
`default_nettype none
package pzpt_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 32;

    // Register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_ZONE_BASE_Z  = 2'd1;
    localparam logic [1:0] REG_ZONE_HEIGHT  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_INSIDE     = 3'd0;
    localparam logic [2:0] ST_OUT_POLY   = 3'd1;
    localparam logic [2:0] ST_HEIGHT     = 3'd2;
    localparam logic [2:0] ST_OUT_BOX    = 3'd3;
    localparam logic [2:0] ST_STORED     = 3'd4;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [5:0]         vertex_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               skip_height;
    } t_in_item;

    typedef struct packed {
        logic       inside_res;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic       load;          // store vertex, fold into box
        logic       query;         // latch query point
        logic       walk_start;    // clear crossing parity
        logic       rd_en;         // vertex read issued
        logic       rd_first;      // read fetches the closing vertex only
        logic       set_res;       // result from res_code
        logic [2:0] res_code;
        logic       set_walk_res;  // result from crossing parity
        logic       out_load;      // move result into output register
    } t_cmd;

    typedef struct packed {
        logic height_fail;
        logic box_fail;
        logic busy;       // edge pipeline still holds work
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: hdl/pzpt_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module pzpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: hdl/pzpt_ctrl.sv
// Sequencer: accept, check, edge walk, drain and result hand-off.
`default_nettype none
module pzpt_ctrl #(
    parameter int MAX_VERTICES = pzpt_pkg::MAX_VERTICES_DEF,
    localparam int IDXW = $clog2(MAX_VERTICES),
    localparam int CNTW = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_mode,
    output logic                 o_in_ready,
    input  wire logic [6:0]      i_vertex_count,
    input  wire pzpt_pkg::t_sts  i_sts,
    output pzpt_pkg::t_cmd       o_cmd,
    output logic [IDXW-1:0]      o_rd_addr
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_WALK  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [CNTW-1:0] w_n;
    logic            w_acc;

    assign w_n = (int'(i_vertex_count) > MAX_VERTICES) ? CNTW'(MAX_VERTICES)
                                                        : CNTW'(i_vertex_count);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_rd_addr = IDXW'(r_cnt);
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_mode == pzpt_pkg::MODE_LOAD) begin
                        o_cmd.load     = 1'b1;
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = pzpt_pkg::ST_STORED;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.query = 1'b1;
                        n_state     = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.height_fail) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = pzpt_pkg::ST_HEIGHT;
                    n_state        = S_DONE;
                end else if (i_sts.box_fail) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = pzpt_pkg::ST_OUT_BOX;
                    n_state        = S_DONE;
                end else if (w_n == '0) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = pzpt_pkg::ST_OUT_POLY;
                    n_state        = S_DONE;
                end else begin
                    // closing vertex first, it is the j side of edge 0
                    o_cmd.walk_start = 1'b1;
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.rd_first   = 1'b1;
                    o_rd_addr        = IDXW'(w_n - 1'b1);
                    n_cnt            = '0;
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.rd_en = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == w_n - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    o_cmd.set_walk_res = 1'b1;
                    n_state            = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.busy)
        else $error("edge pipeline busy while idle");
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cnt < w_n))
        else $error("walk counter beyond vertex count");
    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && !i_sts.busy) |=> (r_state == S_DONE))
        else $error("drain did not finish");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result overwrote pending output");
endmodule
`default_nettype wire

// File: hdl/pzpt_dp.sv
// Datapath: vertex store, bounding box, height check, edge crossing pipeline.
`default_nettype none
module pzpt_dp #(
    parameter int MAX_VERTICES = pzpt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pzpt_pkg::COORD_BITS_DEF,
    localparam int IDXW = $clog2(MAX_VERTICES)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pzpt_pkg::t_cmd     i_cmd,
    input  wire logic [IDXW-1:0]    i_rd_addr,
    output pzpt_pkg::t_sts          o_sts,
    input  wire pzpt_pkg::t_in_item i_item,
    input  wire logic [31:0]        i_zone_base_z,
    input  wire logic [30:0]        i_zone_height,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pzpt_pkg::t_out_item     o_out_item
);
    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [CW-1:0] w_x, w_y;
    logic                 w_we;
    logic signed [CW-1:0] r_px, r_py, r_pz;
    logic                 r_skip;
    logic signed [CW-1:0] r_bx_lo, r_bx_hi, r_by_lo, r_by_hi;

    assign w_x  = i_item.coord_x[CW-1:0];
    assign w_y  = i_item.coord_y[CW-1:0];
    assign w_we = i_cmd.load && (int'(i_item.vertex_index) < MAX_VERTICES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.query) begin
            r_px   <= w_x;
            r_py   <= w_y;
            r_pz   <= i_item.coord_z[CW-1:0];
            r_skip <= i_item.skip_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bx_lo <= '0;
            r_bx_hi <= '0;
            r_by_lo <= '0;
            r_by_hi <= '0;
        end else if (w_we) begin
            if (i_item.vertex_index == 6'd0) begin
                r_bx_lo <= w_x;
                r_bx_hi <= w_x;
                r_by_lo <= w_y;
                r_by_hi <= w_y;
            end else begin
                if (w_x < r_bx_lo) r_bx_lo <= w_x;
                if (w_x > r_bx_hi) r_bx_hi <= w_x;
                if (w_y < r_by_lo) r_by_lo <= w_y;
                if (w_y > r_by_hi) r_by_hi <= w_y;
            end
        end
    end

    // inclusive height range, upper limit formed wide enough not to wrap
    logic signed [CW-1:0] w_base;
    logic signed [33:0]   w_lo, w_hi, w_z;
    assign w_base = i_zone_base_z[CW-1:0];
    assign w_lo   = $signed({{(34-CW){w_base[CW-1]}}, w_base});
    assign w_z    = $signed({{(34-CW){r_pz[CW-1]}}, r_pz});
    assign w_hi   = w_lo + $signed({3'b000, i_zone_height});

    assign o_sts.height_fail = !r_skip && ((w_z < w_lo) || (w_z > w_hi));
    assign o_sts.box_fail    = (r_px < r_bx_lo) || (r_px > r_bx_hi) ||
                               (r_py < r_by_lo) || (r_py > r_by_hi);

    logic [2*CW-1:0] w_rdata;

    pzpt_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_vert_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IDXW'(i_item.vertex_index)),
        .i_wdata ({w_x, w_y}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    logic signed [CW-1:0] w_cx, w_cy, r_jx, r_jy;
    logic                 r_rv, r_rfirst;
    assign w_cx = w_rdata[2*CW-1:CW];
    assign w_cy = w_rdata[CW-1:0];

    // stage 1: i = vertex just read, j = previous vertex
    logic                 r_s1v, r_s1c;
    logic signed [DW-1:0] r_a, r_d, r_b, r_c;
    // stage 2: products
    logic                 r_s2v, r_s2c, r_s2dpos;
    logic signed [PW-1:0] r_lhs, r_rhs;
    logic                 r_par;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv     <= 1'b0;
            r_rfirst <= 1'b0;
            r_s1v    <= 1'b0;
            r_s2v    <= 1'b0;
            r_par    <= 1'b0;
        end else begin
            r_rv     <= i_cmd.rd_en;
            r_rfirst <= i_cmd.rd_first;
            r_s1v    <= r_rv && !r_rfirst;
            r_s2v    <= r_s1v;
            if (i_cmd.walk_start) begin
                r_par <= 1'b0;
            end else if (r_s2v && r_s2c &&
                         (r_s2dpos ? (r_lhs < r_rhs) : (r_rhs < r_lhs))) begin
                r_par <= ~r_par;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rv) begin
            r_jx <= w_cx;
            r_jy <= w_cy;
        end
        r_s1c <= (w_cy > r_py) != (r_jy > r_py);
        r_a   <= $signed({r_px[CW-1], r_px}) - $signed({w_cx[CW-1], w_cx});
        r_d   <= $signed({r_jy[CW-1], r_jy}) - $signed({w_cy[CW-1], w_cy});
        r_b   <= $signed({r_jx[CW-1], r_jx}) - $signed({w_cx[CW-1], w_cx});
        r_c   <= $signed({r_py[CW-1], r_py}) - $signed({w_cy[CW-1], w_cy});
        r_lhs    <= r_a * r_d;
        r_rhs    <= r_b * r_c;
        r_s2c    <= r_s1c;
        r_s2dpos <= (r_d > 0);
    end

    assign o_sts.busy = r_rv || r_s1v || r_s2v;

    logic       r_res_in;
    logic [2:0] r_res_st;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res_in <= 1'b0;
            r_res_st <= i_cmd.res_code;
        end else if (i_cmd.set_walk_res) begin
            r_res_in <= r_par;
            r_res_st <= r_par ? pzpt_pkg::ST_INSIDE : pzpt_pkg::ST_OUT_POLY;
        end
    end

    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_item.inside_res <= r_res_in;
            o_out_item.status     <= r_res_st;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_sts.out_free = !r_ovalid || i_out_ready;
endmodule
`default_nettype wire

// File: hdl/polygon_zone_point_test.sv
// Top level: APB registers, sequencer and datapath of the polygon zone test.
//
//  channel | direction | handshake               | payload
//  input   | in        | i_in_valid / o_in_ready | i_in_item  (t_in_item)
//  result  | out       | o_out_valid/ i_out_ready| o_out_item (t_out_item)
//  config  | in        | psel/penable/pwrite     | paddr, pwdata, prdata
//
//  A load goes from accept straight to the result; a query failing the height
//  or box check passes the check state first; a full query then walks n vertices
//  via the single read port of the vertex RAM (one vertex per cycle) and drains.
//  Synchronous active-low reset clears control, box, base, height; count is 3.
//  A stalled result sits in the output register; the next result waits for it.
`default_nettype none
module polygon_zone_point_test #(
    parameter int MAX_VERTICES = pzpt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pzpt_pkg::COORD_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire pzpt_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output pzpt_pkg::t_out_item      o_out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    localparam int IDXW = $clog2(MAX_VERTICES);

    logic [6:0]  r_vertex_count;
    logic [31:0] r_zone_base_z;
    logic [30:0] r_zone_height;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= 7'd3;
            r_zone_base_z  <= '0;
            r_zone_height  <= '0;
        end else if (w_wr) begin
            case (paddr[3:2])
                pzpt_pkg::REG_VERTEX_COUNT: r_vertex_count <= pwdata[6:0];
                pzpt_pkg::REG_ZONE_BASE_Z:  r_zone_base_z  <= pwdata;
                pzpt_pkg::REG_ZONE_HEIGHT:  r_zone_height  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pzpt_pkg::REG_VERTEX_COUNT: prdata = {25'd0, r_vertex_count};
            pzpt_pkg::REG_ZONE_BASE_Z:  prdata = r_zone_base_z;
            pzpt_pkg::REG_ZONE_HEIGHT:  prdata = {1'b0, r_zone_height};
            default:                    prdata = '0;
        endcase
    end

    pzpt_pkg::t_cmd  w_cmd;
    pzpt_pkg::t_sts  w_sts;
    logic [IDXW-1:0] w_rd_addr;

    pzpt_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_mode         (i_in_item.mode),
        .o_in_ready     (o_in_ready),
        .i_vertex_count (r_vertex_count),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd),
        .o_rd_addr      (w_rd_addr)
    );

    pzpt_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_rd_addr     (w_rd_addr),
        .o_sts         (w_sts),
        .i_item        (i_in_item),
        .i_zone_base_z (r_zone_base_z),
        .i_zone_height (r_zone_height),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_item    (o_out_item)
    );
endmodule
`default_nettype wire

// File: dv/polygon_zone_point_test_tb.sv
// Self-checking testbench for the polygon zone point test block.
`timescale 1ns / 100ps
`default_nettype none
module polygon_zone_point_test_tb;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    pzpt_pkg::t_in_item   i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    pzpt_pkg::t_out_item  o_out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    polygon_zone_point_test u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // zone model state
    logic signed [31:0] poly_x [0:63];
    logic signed [31:0] poly_y [0:63];
    logic signed [31:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;
    logic [6:0]         zone_count;
    logic signed [31:0] zone_base;
    logic [30:0]        zone_span;

    pzpt_pkg::t_out_item verdict_q[$];
    int        error_count;
    int        transfer_count;
    int        query_count;
    int        stall_hold;   // forces a long receiver hold-off when nonzero

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("ERROR t=%0t %s: got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic logic crosses_edge(input int i, input int j,
                                          input logic signed [31:0] px,
                                          input logic signed [31:0] py);
        logic signed [33:0] d;
        logic signed [67:0] lhs, rhs;
        if ((poly_y[i] > py) == (poly_y[j] > py)) return 1'b0;
        d   = 34'(poly_y[j]) - 34'(poly_y[i]);
        lhs = 68'(34'(px) - 34'(poly_x[i])) * 68'(d);
        rhs = 68'(34'(poly_x[j]) - 34'(poly_x[i])) * 68'(34'(py) - 34'(poly_y[i]));
        return (d > 0) ? (lhs < rhs) : (rhs < lhs);
    endfunction

    // fold one item into the zone state and return its verdict
    function automatic pzpt_pkg::t_out_item zone_verdict(input pzpt_pkg::t_in_item it);
        pzpt_pkg::t_out_item r;
        int        n;
        logic      par;
        logic signed [32:0] top;
        r = '0;
        if (it.mode == pzpt_pkg::MODE_LOAD) begin
            poly_x[it.vertex_index] = it.coord_x;
            poly_y[it.vertex_index] = it.coord_y;
            if (it.vertex_index == 0) begin
                box_lo_x = it.coord_x; box_hi_x = it.coord_x;
                box_lo_y = it.coord_y; box_hi_y = it.coord_y;
            end else begin
                if (it.coord_x < box_lo_x) box_lo_x = it.coord_x;
                if (it.coord_x > box_hi_x) box_hi_x = it.coord_x;
                if (it.coord_y < box_lo_y) box_lo_y = it.coord_y;
                if (it.coord_y > box_hi_y) box_hi_y = it.coord_y;
            end
            r.status = pzpt_pkg::ST_STORED;
            return r;
        end
        top = 33'(zone_base) + 33'($signed({1'b0, zone_span}));
        if (!it.skip_height && (it.coord_z < zone_base || 33'(it.coord_z) > top)) begin
            r.status = pzpt_pkg::ST_HEIGHT;
            return r;
        end
        if (it.coord_x < box_lo_x || it.coord_x > box_hi_x ||
            it.coord_y < box_lo_y || it.coord_y > box_hi_y) begin
            r.status = pzpt_pkg::ST_OUT_BOX;
            return r;
        end
        n   = (zone_count > 64) ? 64 : zone_count;
        par = 1'b0;
        for (int i = 0; i < n; i++)
            if (crosses_edge(i, (i == 0) ? n - 1 : i - 1, it.coord_x, it.coord_y))
                par = ~par;
        r.inside_res = par;
        r.status     = par ? pzpt_pkg::ST_INSIDE : pzpt_pkg::ST_OUT_POLY;
        return r;
    endfunction

    task automatic send_item(input pzpt_pkg::t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        verdict_q.push_back(zone_verdict(it));
        transfer_count++;
        if (it.mode == pzpt_pkg::MODE_QUERY) query_count++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // random gap between bursts; a burst keeps valid up
    int burst_left;
    task automatic paced_send(input pzpt_pkg::t_in_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        verdict_q.push_back(zone_verdict(it));
        transfer_count++;
        if (it.mode == pzpt_pkg::MODE_QUERY) query_count++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            pzpt_pkg::REG_VERTEX_COUNT: zone_count = val[6:0];
            pzpt_pkg::REG_ZONE_BASE_Z:  zone_base  = val;
            pzpt_pkg::REG_ZONE_HEIGHT:  zone_span  = val[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        if (burst_left != 0) i_in_valid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic pzpt_pkg::t_in_item make_load(input int idx, input int x,
                                                     input int y);
        pzpt_pkg::t_in_item it;
        it = '0;
        it.mode = pzpt_pkg::MODE_LOAD; it.vertex_index = 6'(idx);
        it.coord_x = x; it.coord_y = y;
        it.coord_z = $urandom; it.skip_height = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic pzpt_pkg::t_in_item make_query(input int x, input int y,
                                                      input int z, input logic skip);
        pzpt_pkg::t_in_item it;
        it = '0;
        it.mode = pzpt_pkg::MODE_QUERY; it.vertex_index = 6'($urandom);
        it.coord_x = x; it.coord_y = y; it.coord_z = z; it.skip_height = skip;
        return it;
    endfunction

    // fills all 64 slots so no query reads an unwritten vertex
    task automatic load_polygon(input int n, input int radius, input logic paced);
        int x, y;
        for (int k = 0; k < 64; k++) begin
            if (k < n) begin
                x = $signed($urandom_range(0, 2 * radius)) - radius;
                y = $signed($urandom_range(0, 2 * radius)) - radius;
            end else begin
                x = $urandom; y = $urandom;
            end
            if (paced) paced_send(make_load(k, x, y));
            else send_item(make_load(k, x, y));
        end
    endtask

    task automatic test_directed();
        apb_write(pzpt_pkg::REG_VERTEX_COUNT, 32'd4);
        // unit square, scaled
        send_item(make_load(0, -256, -256));
        send_item(make_load(1,  256, -256));
        send_item(make_load(2,  256,  256));
        send_item(make_load(3, -256,  256));
        send_item(make_query(0, 0, 0, 1'b0));          // inside, height 0..0
        send_item(make_query(0, 0, 1, 1'b0));          // height fail above
        send_item(make_query(0, 0, -1, 1'b0));         // height fail below
        send_item(make_query(0, 0, 32'h7fffffff, 1'b1));
        send_item(make_query(300, 0, 0, 1'b1));        // outside box
        send_item(make_query(-256, -256, 0, 1'b1));    // on a vertex
        send_item(make_query(256, 0, 0, 1'b1));        // on an edge
        wait_drained();
        apb_write(pzpt_pkg::REG_ZONE_BASE_Z, 32'h80000000);
        apb_write(pzpt_pkg::REG_ZONE_HEIGHT, 32'h7fffffff);
        send_item(make_query(10, 10, 32'h80000000, 1'b0));
        send_item(make_query(10, 10, 32'hffffffff, 1'b0));
        send_item(make_query(10, 10, 32'h7fffffff, 1'b0));
        // extreme coordinates, triangle spanning the full range
        send_item(make_load(0, 32'h80000000, 32'h80000000));
        send_item(make_load(1, 32'h7fffffff, 32'h80000000));
        send_item(make_load(2, 0, 32'h7fffffff));
        send_item(make_load(63, 32'h7fffffff, 32'h7fffffff));
        wait_drained();
        apb_write(pzpt_pkg::REG_VERTEX_COUNT, 32'd3);
        send_item(make_query(0, 0, 0, 1'b1));
        send_item(make_query(32'h7fffffff, 32'h7fffffff, 0, 1'b1));
        wait_drained();
        // every slot written before the walk covers all of them
        load_polygon(64, 1 << 12, 1'b0);
        wait_drained();
        apb_write(pzpt_pkg::REG_VERTEX_COUNT, 32'd127);   // clamps to 64
        send_item(make_query(0, 0, 0, 1'b1));
        wait_drained();
        apb_write(pzpt_pkg::REG_VERTEX_COUNT, 32'd0);     // empty polygon, no walk
        send_item(make_query(0, 0, 0, 1'b1));
        wait_drained();
        apb_write(pzpt_pkg::REG_VERTEX_COUNT, 32'd2);
        send_item(make_query(0, 0, 0, 1'b1));
        wait_drained();
    endtask

    task automatic test_random_zones();
        int n, r, qn;
        int counts[6] = '{3, 64, 5, 17, 8, 40};
        for (int ph = 0; ph < 6; ph++) begin
            n = counts[ph];
            r = (ph == 1) ? 32'h7fffff00 : (1 << $urandom_range(4, 30));
            apb_write(pzpt_pkg::REG_VERTEX_COUNT, 32'(n));
            apb_write(pzpt_pkg::REG_ZONE_BASE_Z, -($urandom_range(0, 1000)));
            apb_write(pzpt_pkg::REG_ZONE_HEIGHT, $urandom_range(0, 2000));
            load_polygon(n, r, 1'b1);
            qn = (n == 64) ? 15 : 30;
            for (int q = 0; q < qn; q++) begin
                if ($urandom_range(0, 9) == 0)
                    paced_send(make_query($urandom, $urandom, $urandom,
                                          1'($urandom)));
                else if ($urandom_range(0, 9) == 0)
                    paced_send(make_load($urandom_range(1, 63), $urandom, $urandom));
                else
                    paced_send(make_query($signed($urandom_range(0, 2 * r)) - r,
                                          $signed($urandom_range(0, 2 * r)) - r,
                                          $signed($urandom_range(0, 3000)) - 1500,
                                          $urandom_range(0, 3) == 0));
            end
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        stall_hold = 300;
        for (int q = 0; q < 16; q++)
            paced_send(make_query($urandom_range(0, 50), $urandom_range(0, 50), 0, 1'b1));
        wait_drained();
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with nothing pending", int'(o_out_item.status), -1);
            end else begin
                if (o_out_item.inside_res !== verdict_q[0].inside_res)
                    report_mismatch("inside_res", int'(o_out_item.inside_res),
                                    int'(verdict_q[0].inside_res));
                if (o_out_item.status !== verdict_q[0].status)
                    report_mismatch("status", int'(o_out_item.status),
                                    int'(verdict_q[0].status));
                void'(verdict_q.pop_front());
            end
        end
    end

    // receiver stall pattern, with one long hold-off when stall_hold is set
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall_hold) @(negedge i_clk);
                stall_hold = 0;
            end
            i_out_ready <= ($urandom_range(0, 3) != 0) || (transfer_count % 200 < 40);
        end
    end

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0; transfer_count = 0; query_count = 0;
        stall_hold = 0; burst_left = 0;
        zone_count = 7'd3; zone_base = '0; zone_span = '0;
        box_lo_x = '0; box_hi_x = '0; box_lo_y = '0; box_hi_y = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);
        test_directed();
        test_random_zones();
        test_backpressure();
        wait_drained();
        $display("Covered %0d transfers (%0d queries) over several zone shapes and settings,",
                 transfer_count, query_count);
        $display("with random sender gaps, receiver stalls and one long hold-off.");
        if (error_count == 0 && verdict_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/pzpt_pkg.sv
hdl/pzpt_ram.sv
hdl/pzpt_ctrl.sv
hdl/pzpt_dp.sv
hdl/polygon_zone_point_test.sv
dv/polygon_zone_point_test_tb.sv
